[hdl/rgbcsc_pkg.sv]
// Package for the RGB color space converter: command and register index codes,
// fixed field widths, reset values and the per-stage sideband record.
// Depends on nothing; the converter top level refers to it by scoped names.
package rgbcsc_pkg;

    localparam int ENCODE_INDEX_BITS_DEF = 12;
    localparam int COEF_FRAC_BITS_DEF    = 14;

    localparam int COEF_W = 18;
    localparam int ROW_W  = 3 * COEF_W;
    localparam int LIN_W  = 16;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 12;
    localparam int CFG_W  = 2;
    localparam int PROD_W = COEF_W + LIN_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'd16384);
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'd16384 << 18);
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'd16384 << 36);

    typedef enum logic [1:0] {
        CMD_PIXEL  = 2'd0,
        CMD_DEC_WR = 2'd1,
        CMD_ENC_WR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_ROW0   = 2'd0,
        CFG_ROW1   = 2'd1,
        CFG_ROW2   = 2'd2,
        CFG_BYPASS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              byp;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              last;
        logic [IDX_W-1:0]  lut_idx;
        logic [BYTE_W-1:0] enc_val;
    } side_t;

endpackage

[hdl/rgb_color_space_converter.sv]
// Top level of the RGB color space converter: decode tables, 3x3 matrix,
// rounding and saturation, encode tables, in a five-stage pipeline.
// Depends on rgbcsc_pkg for codes, widths, reset values and the sideband record.

// The converter takes one beat per clock unless in_stall is raised; the five
// register stages are decode table read, nine parallel coefficient multiplies,
// the three-term sums, rounding with saturation to the encode index, and the
// encode table read, which is also the output register. An encode write uses a
// pipeline slot, a decode write does not, and neither produces an output beat;
// a decode write takes effect at acceptance, an encode write when it
// reaches the last stage, so every pixel sees exactly the writes issued before
// it. Each table is held in three copies, one per color channel, so that all
// three channels are looked up in the same cycle. Neither table is cleared by
// reset, and software must write every entry a pixel can reach before sending
// pixels with bypass off. Stalls propagate backward stage by stage, so empty
// stages are filled while the output is held. Configuration writes are always
// ready and must only be issued while the pipeline is empty.
module rgb_color_space_converter #(
    parameter int ENCODE_INDEX_BITS = rgbcsc_pkg::ENCODE_INDEX_BITS_DEF,
    parameter int COEF_FRAC_BITS    = rgbcsc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgbcsc_pkg::CFG_W-1:0]       cfg_index,
    input  logic [rgbcsc_pkg::ROW_W-1:0]       cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         command,
    input  logic [rgbcsc_pkg::BYTE_W-1:0]      red,
    input  logic [rgbcsc_pkg::BYTE_W-1:0]      green,
    input  logic [rgbcsc_pkg::BYTE_W-1:0]      blue,
    input  logic [rgbcsc_pkg::BYTE_W-1:0]      alpha,
    input  logic                               last_pixel,
    input  logic [rgbcsc_pkg::IDX_W-1:0]       lut_index,
    input  logic [rgbcsc_pkg::LIN_W-1:0]       lut_value,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rgbcsc_pkg::BYTE_W-1:0]      out_red,
    output logic [rgbcsc_pkg::BYTE_W-1:0]      out_green,
    output logic [rgbcsc_pkg::BYTE_W-1:0]      out_blue,
    output logic [rgbcsc_pkg::BYTE_W-1:0]      out_alpha,
    output logic                               out_last
);

    localparam int COEF_W    = rgbcsc_pkg::COEF_W;
    localparam int ROW_W     = rgbcsc_pkg::ROW_W;
    localparam int LIN_W     = rgbcsc_pkg::LIN_W;
    localparam int BYTE_W    = rgbcsc_pkg::BYTE_W;
    localparam int PROD_W    = rgbcsc_pkg::PROD_W;
    localparam int ACC_W     = rgbcsc_pkg::ACC_W;
    localparam int ENC_DEPTH = 1 << ENCODE_INDEX_BITS;
    localparam logic [ACC_W-1:0] ROUND_K = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic [ROW_W-1:0]                    row_reg [3];
    logic                                bypass_reg;

    logic                                v_reg [1:5];
    rgbcsc_pkg::side_t                   side_reg [1:5];
    logic                                ready [1:5];

    rgbcsc_pkg::cmd_t                    in_cmd;
    logic                                accept;
    logic                                v1_next;
    rgbcsc_pkg::side_t                   side1_next;
    logic [BYTE_W-1:0]                   in_byte [3];

    logic [LIN_W-1:0]                    lin_reg [3];
    logic signed [PROD_W-1:0]            prod_next [3][3];
    logic signed [PROD_W-1:0]            prod_reg [3][3];
    logic signed [ACC_W-1:0]             acc_next [3];
    logic signed [ACC_W-1:0]             acc_reg [3];
    logic [ENCODE_INDEX_BITS-1:0]        eidx_next [3];
    logic [ENCODE_INDEX_BITS-1:0]        eidx_reg [3];
    logic [BYTE_W-1:0]                   enc_reg [3];

    logic                                dec_we;
    logic                                enc_we;
    logic [ENCODE_INDEX_BITS-1:0]        enc_waddr;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= rgbcsc_pkg::ROW0_RST;
            row_reg[1] <= rgbcsc_pkg::ROW1_RST;
            row_reg[2] <= rgbcsc_pkg::ROW2_RST;
            bypass_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rgbcsc_pkg::cfg_idx_t'(cfg_index))
                rgbcsc_pkg::CFG_ROW0:   row_reg[0] <= cfg_data;
                rgbcsc_pkg::CFG_ROW1:   row_reg[1] <= cfg_data;
                rgbcsc_pkg::CFG_ROW2:   row_reg[2] <= cfg_data;
                rgbcsc_pkg::CFG_BYPASS: bypass_reg <= cfg_data[0];
                default:                bypass_reg <= bypass_reg;
            endcase
        end
    end

    // Backward flow control: a stage loads when it is empty or moves on.
    assign ready[5] = !v_reg[5] || !out_stall || (side_reg[5].cmd != rgbcsc_pkg::CMD_PIXEL);
    assign ready[4] = !v_reg[4] || ready[5];
    assign ready[3] = !v_reg[3] || ready[4];
    assign ready[2] = !v_reg[2] || ready[3];
    assign ready[1] = !v_reg[1] || ready[2];

    assign in_stall = !ready[1];
    assign accept   = in_valid && ready[1];
    assign in_cmd   = rgbcsc_pkg::cmd_t'(command);

    always_comb
    begin
        side1_next.cmd     = in_cmd;
        side1_next.byp     = bypass_reg;
        side1_next.red     = red;
        side1_next.green   = green;
        side1_next.blue    = blue;
        side1_next.alpha   = alpha;
        side1_next.last    = last_pixel;
        side1_next.lut_idx = lut_index;
        side1_next.enc_val = lut_value[BYTE_W-1:0];
        case (in_cmd)
            rgbcsc_pkg::CMD_PIXEL:  v1_next = in_valid;
            rgbcsc_pkg::CMD_ENC_WR: v1_next = in_valid;
            rgbcsc_pkg::CMD_DEC_WR: v1_next = 1'b0;
            default:                v1_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 5; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (ready[1])
            begin
                v_reg[1] <= v1_next;
            end
            for (int k = 2; k <= 5; k++)
            begin
                if (ready[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            side_reg[1] <= side1_next;
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (ready[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign in_byte[0] = red;
    assign in_byte[1] = green;
    assign in_byte[2] = blue;

    assign dec_we    = accept && (in_cmd == rgbcsc_pkg::CMD_DEC_WR);
    assign enc_we    = ready[5] && v_reg[4] && (side_reg[4].cmd == rgbcsc_pkg::CMD_ENC_WR);
    assign enc_waddr = ENCODE_INDEX_BITS'(side_reg[4].lut_idx);

    // One copy of each table per channel, so each copy has a single read port.
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic [LIN_W-1:0]  dec_mem [256];
        logic [BYTE_W-1:0] enc_mem [ENC_DEPTH];

        always_ff @(posedge clk)
        begin
            if (dec_we)
            begin
                dec_mem[lut_index[BYTE_W-1:0]] <= lut_value;
            end
            if (ready[1])
            begin
                lin_reg[c] <= dec_mem[in_byte[c]];
            end
        end

        always_ff @(posedge clk)
        begin
            if (enc_we)
            begin
                enc_mem[enc_waddr] <= side_reg[4].enc_val;
            end
            if (ready[5])
            begin
                enc_reg[c] <= enc_mem[eidx_reg[c]];
            end
        end
    end

    // Stage 2: nine coefficient products.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[c][k] = $signed(row_reg[c][COEF_W*k +: COEF_W])
                                * $signed({1'b0, lin_reg[k]});
            end
        end
    end

    // Stage 3: row sums.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = ACC_W'(prod_reg[c][0]) + ACC_W'(prod_reg[c][1])
                        + ACC_W'(prod_reg[c][2]);
        end
    end

    // Stage 4: round half up, clamp to the linear range, take the encode index.
    always_comb
    begin
        logic [ACC_W-1:0] rnd;
        logic [ACC_W-1:0] shf;
        logic [LIN_W-1:0] lin_out;
        for (int c = 0; c < 3; c++)
        begin
            rnd = $unsigned(acc_reg[c]) + ROUND_K;
            shf = rnd >> COEF_FRAC_BITS;
            if (acc_reg[c] <= 0)
            begin
                lin_out = '0;
            end
            else if (|shf[ACC_W-1:LIN_W])
            begin
                lin_out = '1;
            end
            else
            begin
                lin_out = shf[LIN_W-1:0];
            end
            eidx_next[c] = lin_out[LIN_W-1 -: ENCODE_INDEX_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            prod_reg <= prod_next;
        end
        if (ready[3])
        begin
            acc_reg <= acc_next;
        end
        if (ready[4])
        begin
            eidx_reg <= eidx_next;
        end
    end

    assign out_valid = v_reg[5] && (side_reg[5].cmd == rgbcsc_pkg::CMD_PIXEL);
    assign out_red   = side_reg[5].byp ? side_reg[5].red   : enc_reg[0];
    assign out_green = side_reg[5].byp ? side_reg[5].green : enc_reg[1];
    assign out_blue  = side_reg[5].byp ? side_reg[5].blue  : enc_reg[2];
    assign out_alpha = side_reg[5].alpha;
    assign out_last  = side_reg[5].last;

endmodule

[dv/rgbcsc_tb_pkg.sv]
`timescale 1ns / 100ps
// Beat records and the pixel scoreboard for the color space converter bench.
// Depends on rgbcsc_pkg for command and register codes, widths and reset rows.
package rgbcsc_tb_pkg;

    import rgbcsc_pkg::*;

    localparam int         ENC_DEPTH  = 1 << ENCODE_INDEX_BITS_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              last_pixel;
        logic [IDX_W-1:0]  lut_index;
        logic [LIN_W-1:0]  lut_value;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              last;
    } out_beat_t;

    class pixel_checker;
        logic [ROW_W-1:0]  rows [3];
        bit                bypass;
        logic [LIN_W-1:0]  decode_lut [256];
        logic [BYTE_W-1:0] encode_lut [ENC_DEPTH];
        bit                decode_set [256];
        bit                encode_set [ENC_DEPTH];
        out_beat_t         pending_pixels [$];
        int unsigned       mismatches;

        function new();
            rows[0] = ROW0_RST;
            rows[1] = ROW1_RST;
            rows[2] = ROW2_RST;
            bypass = 1'b1;
            mismatches = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [ROW_W-1:0] data);
            case (idx)
                CFG_ROW0:   rows[0] = data;
                CFG_ROW1:   rows[1] = data;
                CFG_ROW2:   rows[2] = data;
                CFG_BYPASS: bypass = data[0];
                default: ;
            endcase
        endfunction

        function logic [LIN_W-1:0] mix_channel(logic [ROW_W-1:0] row, logic [BYTE_W-1:0] r,
                                               logic [BYTE_W-1:0] g, logic [BYTE_W-1:0] b);
            logic signed [COEF_W-1:0] coef;
            logic [LIN_W-1:0]         lin [3];
            longint                   acc;
            longint                   rounded;
            lin[0] = decode_lut[r];
            lin[1] = decode_lut[g];
            lin[2] = decode_lut[b];
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                coef = row[k*COEF_W +: COEF_W];
                acc += longint'(coef) * longint'(lin[k]);
            end
            if (acc <= 0)
                return '0;
            rounded = (acc + (longint'(1) << (COEF_FRAC_BITS_DEF - 1))) >>> COEF_FRAC_BITS_DEF;
            if (rounded > 65535)
                return '1;
            return LIN_W'(rounded);
        endfunction

        function logic [IDX_W-1:0] encode_slot(int k, logic [BYTE_W-1:0] r,
                                                logic [BYTE_W-1:0] g, logic [BYTE_W-1:0] b);
            logic [LIN_W-1:0] level;
            level = mix_channel(rows[k], r, g, b);
            return IDX_W'(level >> (LIN_W - ENCODE_INDEX_BITS_DEF));
        endfunction

        function void note_input(in_beat_t beat);
            out_beat_t want;
            case (beat.command)
                CMD_DEC_WR:
                begin
                    decode_lut[beat.lut_index[7:0]] = beat.lut_value;
                    decode_set[beat.lut_index[7:0]] = 1'b1;
                end
                CMD_ENC_WR:
                begin
                    encode_lut[beat.lut_index] = beat.lut_value[BYTE_W-1:0];
                    encode_set[beat.lut_index] = 1'b1;
                end
                CMD_PIXEL:
                begin
                    if (bypass)
                    begin
                        want.red = beat.red;
                        want.green = beat.green;
                        want.blue = beat.blue;
                    end
                    else
                    begin
                        want.red = encode_lut[encode_slot(0, beat.red, beat.green, beat.blue)];
                        want.green = encode_lut[encode_slot(1, beat.red, beat.green, beat.blue)];
                        want.blue = encode_lut[encode_slot(2, beat.red, beat.green, beat.blue)];
                    end
                    want.alpha = beat.alpha;
                    want.last = beat.last_pixel;
                    pending_pixels.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: output beat with no pixel pending, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("out_red", want.red, got.red);
            compare_field("out_green", want.green, got.green);
            compare_field("out_blue", want.blue, got.blue);
            compare_field("out_alpha", want.alpha, got.alpha);
            compare_field("out_last", BYTE_W'(want.last), BYTE_W'(got.last));
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

endpackage

[dv/rgb_color_space_converter_tb.sv]
`timescale 1ns / 100ps
// Top-level bench for rgb_color_space_converter: directed and random pixel and
// table traffic with random stalls, checked beat by beat against pixel_checker.
// Depends on rgbcsc_pkg and rgbcsc_tb_pkg.
module rgb_color_space_converter_tb;

    import rgbcsc_pkg::*;
    import rgbcsc_tb_pkg::*;

    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 250;
    localparam int HOLD_PHASE     = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int PIPE_FLUSH     = 10;
    localparam int WATCHDOG_LIMIT = 3000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_idx_t          cfg_index = CFG_ROW0;
    logic [ROW_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        command = CMD_PIXEL;
    logic [BYTE_W-1:0] red = '0;
    logic [BYTE_W-1:0] green = '0;
    logic [BYTE_W-1:0] blue = '0;
    logic [BYTE_W-1:0] alpha = '0;
    logic              last_pixel = 1'b0;
    logic [IDX_W-1:0]  lut_index = '0;
    logic [LIN_W-1:0]  lut_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_red;
    logic [BYTE_W-1:0] out_green;
    logic [BYTE_W-1:0] out_blue;
    logic [BYTE_W-1:0] out_alpha;
    logic              out_last;

    pixel_checker sb;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    bit           hold_request = 1'b0;
    int           stall_left = 0;
    int           quiet_cycles = 0;
    int           beats_sent = 0;
    out_beat_t    seen_beat;

    rgb_color_space_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last_pixel (last_pixel),
        .lut_index  (lut_index),
        .lut_value  (lut_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .out_last   (out_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        logic [COEF_W-1:0] coef [3];
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                coef[k] = COEF_W'($urandom);
            else
                coef[k] = COEF_W'(int'($urandom_range(0, 40000)) - 20000);
        end
        return {coef[2], coef[1], coef[0]};
    endfunction

    function automatic in_beat_t pixel_beat(logic [BYTE_W-1:0] r, logic [BYTE_W-1:0] g,
                                            logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] a,
                                            logic mark);
        in_beat_t beat;
        beat.command = CMD_PIXEL;
        beat.red = r;
        beat.green = g;
        beat.blue = b;
        beat.alpha = a;
        beat.last_pixel = mark;
        beat.lut_index = IDX_W'($urandom);
        beat.lut_value = LIN_W'($urandom);
        return beat;
    endfunction

    function automatic in_beat_t lut_write(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                                           logic [LIN_W-1:0] value);
        in_beat_t beat;
        beat = pixel_beat(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'($urandom));
        beat.command = cmd;
        beat.lut_index = idx;
        beat.lut_value = value;
        return beat;
    endfunction

    task automatic send_beat(input in_beat_t beat);
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= beat.command;
        red <= beat.red;
        green <= beat.green;
        blue <= beat.blue;
        alpha <= beat.alpha;
        last_pixel <= beat.last_pixel;
        lut_index <= beat.lut_index;
        lut_value <= beat.lut_value;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input(beat);
        if (beat.command != CMD_UNUSED)
            beats_sent++;
    endtask

    // With bypass off, any table entry that the pixel will read gets written first.
    task automatic send_pixel(input in_beat_t px);
        logic [BYTE_W-1:0] chan [3];
        logic [IDX_W-1:0]  slot;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        px.command = CMD_PIXEL;
        if (!sb.bypass)
        begin
            for (int k = 0; k < 3; k++)
                if (!sb.decode_set[chan[k]])
                    send_beat(lut_write(CMD_DEC_WR, {4'($urandom), chan[k]}, LIN_W'($urandom)));
            for (int k = 0; k < 3; k++)
            begin
                slot = sb.encode_slot(k, px.red, px.green, px.blue);
                if (!sb.encode_set[slot])
                    send_beat(lut_write(CMD_ENC_WR, slot, LIN_W'($urandom)));
            end
        end
        send_beat(px);
    endtask

    task automatic random_item();
        in_beat_t beat;
        int       pick;
        beat = pixel_beat(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'($urandom));
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            beat.command = CMD_DEC_WR;
            send_beat(beat);
        end
        else if (pick < 4)
        begin
            beat.command = CMD_ENC_WR;
            send_beat(beat);
        end
        else if (pick == 4)
        begin
            beat.command = CMD_UNUSED;
            send_beat(beat);
        end
        else
            send_pixel(beat);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    task automatic write_settings(input logic [ROW_W-1:0] row0, input logic [ROW_W-1:0] row1,
                                  input logic [ROW_W-1:0] row2, input bit byp);
        cfg_idx_t         regs [4];
        logic [ROW_W-1:0] vals [4];
        regs[0] = CFG_ROW0;
        regs[1] = CFG_ROW1;
        regs[2] = CFG_ROW2;
        regs[3] = CFG_BYPASS;
        vals[0] = row0;
        vals[1] = row1;
        vals[2] = row2;
        vals[3] = {(ROW_W-1)'({$urandom, $urandom}), byp};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            sb.set_register(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        in_beat_t beat;
        send_beat(pixel_beat('0, '0, '0, '0, 1'b0));
        send_beat(pixel_beat('1, '1, '1, '1, 1'b1));
        beat = pixel_beat(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'b1);
        beat.command = CMD_UNUSED;
        send_beat(beat);
        send_beat(lut_write(CMD_DEC_WR, 12'hF00, 16'h0000));
        send_beat(lut_write(CMD_DEC_WR, 12'h0FF, 16'hFFFF));
        send_beat(lut_write(CMD_DEC_WR, 12'h001, 16'd8192));
        send_beat(lut_write(CMD_DEC_WR, 12'h002, 16'd8191));
        send_beat(lut_write(CMD_ENC_WR, 12'h000, 16'hFF00));
        send_beat(lut_write(CMD_ENC_WR, 12'hFFF, 16'h00FF));

        drain();
        write_settings(ROW0_RST, ROW1_RST, ROW2_RST, 1'b0);
        send_pixel(pixel_beat('0, '0, '0, 8'h5A, 1'b0));
        send_pixel(pixel_beat('1, '1, '1, 8'hA5, 1'b1));
        send_pixel(pixel_beat(8'h01, 8'h02, 8'hFF, 8'h3C, 1'b0));

        // The smallest coefficient shows the round-half-up edge; full-scale
        // positive and negative rows drive saturation at both ends.
        drain();
        write_settings({18'd0, 18'd0, 18'd1}, {3{18'h1FFFF}}, {3{18'h20000}}, 1'b0);
        send_pixel(pixel_beat(8'h01, 8'h01, 8'h01, 8'h11, 1'b0));
        send_pixel(pixel_beat(8'h02, 8'h02, 8'h02, 8'h22, 1'b1));
        send_pixel(pixel_beat(8'hFF, 8'h00, 8'h01, 8'h33, 1'b0));
        send_pixel(pixel_beat(8'h00, 8'hFF, 8'h02, 8'h44, 1'b1));
    endtask

    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
            begin
                seen_beat.red = out_red;
                seen_beat.green = out_green;
                seen_beat.blue = out_blue;
                seen_beat.alpha = out_alpha;
                seen_beat.last = out_last;
                sb.check_result(seen_beat);
            end
            if (stall_left != 0)
                stall_left--;
            else if (hold_request)
            begin
                stall_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 13);
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_start;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            write_settings(rand_row(), rand_row(), rand_row(), phase % 4 == 1);
            if (phase == RANDOM_PHASES - 1)
                rx_idle_on = 1'b0;
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                tx_idle_on = (phase != RANDOM_PHASES - 1)
                             && !(phase == HOLD_PHASE && beats_sent - phase_start < 80);
                random_item();
            end
        end
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/rgbcsc_pkg.sv
hdl/rgb_color_space_converter.sv
dv/rgbcsc_tb_pkg.sv
dv/rgb_color_space_converter_tb.sv
